// ===== sv/wmmd_pkg.sv =====
// Package for the waveform min/max decimator: field widths, register map,
// reset values and the types shared between the submodules.
// No dependencies.
`default_nettype none

package wmmd_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int Y_WIDTH      = 13;
    localparam int HEIGHT_WIDTH = 12;
    localparam int SEG_WIDTH    = 24;
    localparam int SCALE_WIDTH  = 32;
    localparam int SCALE_FRAC   = 20;
    localparam int Y_SHIFT      = 16;
    localparam int YPROD_WIDTH  = SAMPLE_WIDTH + HEIGHT_WIDTH + 1;

    localparam int APB_ADDR_WIDTH = 4;
    localparam int APB_DATA_WIDTH = 32;

    typedef enum logic [1:0] {
        REG_SAMPLES_PER_SEGMENT = 2'd0,
        REG_X_SCALE_Q20         = 2'd1,
        REG_PLOT_HEIGHT         = 2'd2,
        REG_UNUSED              = 2'd3
    } reg_index_t;

    localparam logic [SEG_WIDTH-1:0]    SPS_RESET    = 24'd1;
    localparam logic [SCALE_WIDTH-1:0]  SCALE_RESET  = 32'h0010_0000;
    localparam logic [HEIGHT_WIDTH-1:0] HEIGHT_RESET = 12'd256;

    // round-toward-zero bias for the signed shift by Y_SHIFT
    localparam logic [YPROD_WIDTH-1:0] Y_BIAS = YPROD_WIDTH'((1 << Y_SHIFT) - 1);

    typedef struct packed {
        logic [SEG_WIDTH-1:0]    samples_per_segment;
        logic [SCALE_WIDTH-1:0]  x_scale_q20;
        logic [HEIGHT_WIDTH-1:0] plot_height;
    } cfg_t;

    typedef struct packed {
        logic two_points;
        logic frame_last;
    } seg_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/wmmd_regs.sv =====
// APB configuration registers of the min/max decimator.
// Depends on wmmd_pkg.
`default_nettype none

module wmmd_regs (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [wmmd_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  wire logic [wmmd_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic      [wmmd_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                      pready,
    output wmmd_pkg::cfg_t                            cfg
);

    wmmd_pkg::cfg_t         cfg_reg;
    wmmd_pkg::reg_index_t   reg_sel;
    logic                   wr_en;

    assign reg_sel = wmmd_pkg::reg_index_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.samples_per_segment <= wmmd_pkg::SPS_RESET;
            cfg_reg.x_scale_q20         <= wmmd_pkg::SCALE_RESET;
            cfg_reg.plot_height         <= wmmd_pkg::HEIGHT_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                wmmd_pkg::REG_SAMPLES_PER_SEGMENT: begin
                    cfg_reg.samples_per_segment <= pwdata[wmmd_pkg::SEG_WIDTH-1:0];
                end
                wmmd_pkg::REG_X_SCALE_Q20: begin
                    cfg_reg.x_scale_q20 <= pwdata[wmmd_pkg::SCALE_WIDTH-1:0];
                end
                wmmd_pkg::REG_PLOT_HEIGHT: begin
                    cfg_reg.plot_height <= pwdata[wmmd_pkg::HEIGHT_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            wmmd_pkg::REG_SAMPLES_PER_SEGMENT: begin
                prdata = wmmd_pkg::APB_DATA_WIDTH'(cfg_reg.samples_per_segment);
            end
            wmmd_pkg::REG_X_SCALE_Q20: begin
                prdata = wmmd_pkg::APB_DATA_WIDTH'(cfg_reg.x_scale_q20);
            end
            wmmd_pkg::REG_PLOT_HEIGHT: begin
                prdata = wmmd_pkg::APB_DATA_WIDTH'(cfg_reg.plot_height);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/wmmd_tracker.sv =====
// Segment tracker: running min/max with indices, segment close detection and
// the registered segment record (extremes in index order).
// Depends on wmmd_pkg.
`default_nettype none

module wmmd_tracker #(
    parameter int INDEX_WIDTH = 24
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic [wmmd_pkg::SEG_WIDTH-1:0]           samples_per_segment,
    input  wire logic                                     s_valid,
    output logic                                          s_ready,
    input  wire logic signed [wmmd_pkg::SAMPLE_WIDTH-1:0] s_sample,
    input  wire logic                                     s_last,
    output logic                                          rec_valid,
    input  wire logic                                     rec_ready,
    output wmmd_pkg::seg_ctrl_t                           rec_ctrl,
    output logic [INDEX_WIDTH-1:0]                        rec_first_index,
    output logic signed [wmmd_pkg::SAMPLE_WIDTH-1:0]      rec_first_sample,
    output logic [INDEX_WIDTH-1:0]                        rec_second_index,
    output logic signed [wmmd_pkg::SAMPLE_WIDTH-1:0]      rec_second_sample
);

    localparam int SW = wmmd_pkg::SAMPLE_WIDTH;
    localparam int GW = wmmd_pkg::SEG_WIDTH;

    logic [INDEX_WIDTH-1:0] sample_index_reg, sample_index_next;
    logic [GW-1:0]          seg_pos_reg, seg_pos_next;
    logic signed [SW-1:0]   seg_max_reg, seg_max_next;
    logic signed [SW-1:0]   seg_min_reg, seg_min_next;
    logic [INDEX_WIDTH-1:0] max_index_reg, max_index_next;
    logic [INDEX_WIDTH-1:0] min_index_reg, min_index_next;

    logic                   rec_valid_reg, rec_valid_next;
    wmmd_pkg::seg_ctrl_t    rec_ctrl_reg, rec_ctrl_next;
    logic [INDEX_WIDTH-1:0] first_index_reg, first_index_next;
    logic signed [SW-1:0]   first_sample_reg, first_sample_next;
    logic [INDEX_WIDTH-1:0] second_index_reg, second_index_next;
    logic signed [SW-1:0]   second_sample_reg, second_sample_next;

    logic          accept;
    logic          seg_close;
    logic [GW-1:0] seg_len;
    logic [GW-1:0] pos_inc;

    assign s_ready = !rec_valid_reg || rec_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        seg_len = (samples_per_segment == '0) ? GW'(1) : samples_per_segment;
        pos_inc = seg_pos_reg + GW'(1);

        if (seg_pos_reg == '0) begin
            seg_max_next   = s_sample;
            seg_min_next   = s_sample;
            max_index_next = sample_index_reg;
            min_index_next = sample_index_reg;
        end else begin
            seg_max_next   = seg_max_reg;
            seg_min_next   = seg_min_reg;
            max_index_next = max_index_reg;
            min_index_next = min_index_reg;
            if (s_sample > seg_max_reg) begin
                seg_max_next   = s_sample;
                max_index_next = sample_index_reg;
            end
            if (s_sample < seg_min_reg) begin
                seg_min_next   = s_sample;
                min_index_next = sample_index_reg;
            end
        end

        seg_close = (pos_inc >= seg_len) || (pos_inc == '0) || s_last;

        seg_pos_next      = seg_close ? '0 : pos_inc;
        sample_index_next = s_last ? '0 : sample_index_reg + INDEX_WIDTH'(1);

        // extremes leave in index order; one point (the minimum) on a shared index
        if (max_index_next < min_index_next) begin
            first_index_next   = max_index_next;
            first_sample_next  = seg_max_next;
            second_index_next  = min_index_next;
            second_sample_next = seg_min_next;
        end else begin
            first_index_next   = min_index_next;
            first_sample_next  = seg_min_next;
            second_index_next  = max_index_next;
            second_sample_next = seg_max_next;
        end
        rec_ctrl_next.two_points = (max_index_next != min_index_next);
        rec_ctrl_next.frame_last = s_last;

        if (accept) begin
            rec_valid_next = seg_close;
        end else if (rec_ready) begin
            rec_valid_next = 1'b0;
        end else begin
            rec_valid_next = rec_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_index_reg <= '0;
            seg_pos_reg      <= '0;
            rec_valid_reg    <= 1'b0;
        end else begin
            rec_valid_reg <= rec_valid_next;
            if (accept) begin
                sample_index_reg <= sample_index_next;
                seg_pos_reg      <= seg_pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            seg_max_reg   <= seg_max_next;
            seg_min_reg   <= seg_min_next;
            max_index_reg <= max_index_next;
            min_index_reg <= min_index_next;
            if (seg_close) begin
                rec_ctrl_reg      <= rec_ctrl_next;
                first_index_reg   <= first_index_next;
                first_sample_reg  <= first_sample_next;
                second_index_reg  <= second_index_next;
                second_sample_reg <= second_sample_next;
            end
        end
    end

    assign rec_valid         = rec_valid_reg;
    assign rec_ctrl          = rec_ctrl_reg;
    assign rec_first_index   = first_index_reg;
    assign rec_first_sample  = first_sample_reg;
    assign rec_second_index  = second_index_reg;
    assign rec_second_sample = second_sample_reg;

endmodule

`default_nettype wire

// ===== sv/wmmd_emitter.sv =====
// Point emitter: scales the extremes of a segment record to plot
// coordinates, one point per request, into the output register; the second
// point of a pair waits in a holding register. Depends on wmmd_pkg.
`default_nettype none

module wmmd_emitter #(
    parameter int INDEX_WIDTH = 24,
    parameter int COORD_WIDTH = 12
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic [wmmd_pkg::SCALE_WIDTH-1:0]         x_scale_q20,
    input  wire logic [wmmd_pkg::HEIGHT_WIDTH-1:0]        plot_height,
    input  wire logic                                     rec_valid,
    output logic                                          rec_ready,
    input  wire wmmd_pkg::seg_ctrl_t                      rec_ctrl,
    input  wire logic [INDEX_WIDTH-1:0]                   rec_first_index,
    input  wire logic signed [wmmd_pkg::SAMPLE_WIDTH-1:0] rec_first_sample,
    input  wire logic [INDEX_WIDTH-1:0]                   rec_second_index,
    input  wire logic signed [wmmd_pkg::SAMPLE_WIDTH-1:0] rec_second_sample,
    output logic                                          m_valid,
    input  wire logic                                     m_ready,
    output logic [COORD_WIDTH-1:0]                        m_point_x,
    output logic signed [wmmd_pkg::Y_WIDTH-1:0]           m_point_y,
    output logic                                          m_run_last,
    output logic                                          m_frame_last
);

    localparam int SW = wmmd_pkg::SAMPLE_WIDTH;
    localparam int YW = wmmd_pkg::Y_WIDTH;
    localparam int PW = INDEX_WIDTH + wmmd_pkg::SCALE_WIDTH;
    localparam int XW = PW - wmmd_pkg::SCALE_FRAC;
    localparam int QW = wmmd_pkg::YPROD_WIDTH;

    logic                   phase_reg, phase_next;
    logic                   m_valid_reg, m_valid_next;
    logic [COORD_WIDTH-1:0] point_x_reg, point_x_next;
    logic signed [YW-1:0]   point_y_reg, point_y_next;
    logic                   run_last_reg, run_last_next;
    logic                   frame_last_reg, frame_last_next;
    logic [INDEX_WIDTH-1:0] hold_index_reg;
    logic signed [SW-1:0]   hold_sample_reg;
    logic                   hold_frame_reg;

    logic [INDEX_WIDTH-1:0] cur_index;
    logic signed [SW-1:0]   cur_sample;
    logic                   advance;
    logic                   is_final;
    logic                   load;
    logic [PW-1:0]          x_prod;
    logic [XW-1:0]          x_full;
    logic signed [QW-1:0]   y_prod;
    logic [QW-1:0]          y_adj;
    logic [YW-1:0]          y_quot;

    assign advance    = !m_valid_reg || m_ready;
    assign cur_index  = phase_reg ? hold_index_reg  : rec_first_index;
    assign cur_sample = phase_reg ? hold_sample_reg : rec_first_sample;
    assign is_final   = phase_reg || !rec_ctrl.two_points;
    assign load       = advance && (phase_reg || rec_valid);
    assign rec_ready  = advance && rec_valid && !phase_reg;

    always_comb begin
        x_prod = PW'(cur_index) * PW'(x_scale_q20);
        x_full = x_prod[PW-1:wmmd_pkg::SCALE_FRAC];
        if (x_full[XW-1:COORD_WIDTH] != '0) begin
            point_x_next = '1;
        end else begin
            point_x_next = x_full[COORD_WIDTH-1:0];
        end

        // quotient by 2^16 truncated toward zero, then negated
        y_prod = cur_sample * $signed({1'b0, plot_height});
        y_adj  = y_prod[QW-1] ? QW'(y_prod) + wmmd_pkg::Y_BIAS : QW'(y_prod);
        y_quot = y_adj[QW-1:wmmd_pkg::Y_SHIFT];
        point_y_next = $signed(YW'(-y_quot));

        run_last_next   = is_final;
        frame_last_next = is_final && (phase_reg ? hold_frame_reg : rec_ctrl.frame_last);

        if (load) begin
            phase_next   = !is_final;
            m_valid_next = 1'b1;
        end else begin
            phase_next   = phase_reg;
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            point_x_reg    <= point_x_next;
            point_y_reg    <= point_y_next;
            run_last_reg   <= run_last_next;
            frame_last_reg <= frame_last_next;
        end
        if (rec_ready) begin
            hold_index_reg  <= rec_second_index;
            hold_sample_reg <= rec_second_sample;
            hold_frame_reg  <= rec_ctrl.frame_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_point_x    = point_x_reg;
    assign m_point_y    = point_y_reg;
    assign m_run_last   = run_last_reg;
    assign m_frame_last = frame_last_reg;

endmodule

`default_nettype wire

// ===== sv/waveform_minmax_decimator_unit.sv =====
// Waveform min/max decimator, top level: APB registers, segment tracker
// and point emitter. Depends on wmmd_pkg, wmmd_regs, wmmd_tracker, wmmd_emitter.
//
// Usage:
//   s_ channel carries one signed 16-bit sample per request; s_tlast marks the
//   final sample of a data set and flushes the open segment.
//   m_ channel carries plot points: x and y in m_tdata, the end-of-segment flag
//   in m_tuser and the end-of-data-set flag in m_tlast.
//   The APB port sets segment length, x scale and plot height; write it only
//   while no sample is in flight.
// The sample that closes a segment is registered into the record stage, and
//   the output register takes the segment's first point from there.
// Throughput: one sample per cycle unless the record stage is held; the second point
//   of a pair is sent from a holding register in the emitter, so the record stage
//   frees after the first point. A one-point segment closing right behind a pair
//   waits in the record stage while the second point is sent; the input stalls meanwhile.
// Reset (aresetn low, synchronous) empties the pipeline, restarts the index
//   and loads the register defaults.
// When m_tready is low the output register holds its point, the record stage
//   fills, and s_tready drops once both are occupied.
`default_nettype none

module waveform_minmax_decimator_unit #(
    parameter int INDEX_WIDTH = 24,
    parameter int COORD_WIDTH = 12
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [wmmd_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [wmmd_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic      [wmmd_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                     pready,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [wmmd_pkg::SAMPLE_WIDTH-1:0]   s_tdata,  // [15:0] sample
    input  wire logic                                s_tlast,  // last_sample
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [8*((COORD_WIDTH+wmmd_pkg::Y_WIDTH+7)/8)-1:0] m_tdata, // point_x, point_y
    output logic                                     m_tuser,  // run_last
    output logic                                     m_tlast   // frame_last
);

    localparam int YW = wmmd_pkg::Y_WIDTH;
    localparam int DW = 8 * ((COORD_WIDTH + YW + 7) / 8);
    localparam int PADW = DW - COORD_WIDTH - YW;

    wmmd_pkg::cfg_t         cfg;
    logic                   rec_valid;
    logic                   rec_ready;
    wmmd_pkg::seg_ctrl_t    rec_ctrl;
    logic [INDEX_WIDTH-1:0] rec_first_index;
    logic [INDEX_WIDTH-1:0] rec_second_index;
    logic signed [wmmd_pkg::SAMPLE_WIDTH-1:0] rec_first_sample;
    logic signed [wmmd_pkg::SAMPLE_WIDTH-1:0] rec_second_sample;
    logic [COORD_WIDTH-1:0] point_x;
    logic signed [YW-1:0]   point_y;

    wmmd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wmmd_tracker #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_tracker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .samples_per_segment (cfg.samples_per_segment),
        .s_valid             (s_tvalid),
        .s_ready             (s_tready),
        .s_sample            ($signed(s_tdata)),
        .s_last              (s_tlast),
        .rec_valid           (rec_valid),
        .rec_ready           (rec_ready),
        .rec_ctrl            (rec_ctrl),
        .rec_first_index     (rec_first_index),
        .rec_first_sample    (rec_first_sample),
        .rec_second_index    (rec_second_index),
        .rec_second_sample   (rec_second_sample)
    );

    wmmd_emitter #(
        .INDEX_WIDTH (INDEX_WIDTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_emitter (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .x_scale_q20       (cfg.x_scale_q20),
        .plot_height       (cfg.plot_height),
        .rec_valid         (rec_valid),
        .rec_ready         (rec_ready),
        .rec_ctrl          (rec_ctrl),
        .rec_first_index   (rec_first_index),
        .rec_first_sample  (rec_first_sample),
        .rec_second_index  (rec_second_index),
        .rec_second_sample (rec_second_sample),
        .m_valid           (m_tvalid),
        .m_ready           (m_tready),
        .m_point_x         (point_x),
        .m_point_y         (point_y),
        .m_run_last        (m_tuser),
        .m_frame_last      (m_tlast)
    );

    generate
        if (PADW > 0) begin : g_pad
            assign m_tdata = {{PADW{1'b0}}, point_y, point_x};
        end else begin : g_nopad
            assign m_tdata = {point_y, point_x};
        end
    endgenerate

endmodule

`default_nettype wire

// ===== sv/wmmd_checker.sv =====
// Port-level checks for the waveform min/max decimator, bound to the top level.
// Depends on waveform_minmax_decimator_unit.
`default_nettype none

module wmmd_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  pready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [DATA_WIDTH-1:0] m_tdata,
    input wire logic                  m_tuser,
    input wire logic                  m_tlast
);

    // nothing leaves the output stage in the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // end of data set is always the end of a segment's points
    a_frame_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("frame_last without run_last");

    // the second point of a segment follows its first without a gap
    a_pair_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tuser |=> m_tvalid)
        else $error("second point of a pair missing");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled point changed");

    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind waveform_minmax_decimator_unit wmmd_checker #(
    .DATA_WIDTH (8 * ((COORD_WIDTH + wmmd_pkg::Y_WIDTH + 7) / 8))
) u_wmmd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .pready   (pready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking bench for waveform_minmax_decimator_unit: directed and random
// sample streams against an in-bench envelope predictor, with APB set-up.
// Depends on wmmd_pkg and the decimator RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 250000;
    localparam int SETTLE      = 10;

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
    } sample_req_t;

    typedef struct {
        logic [11:0]        x;
        logic signed [12:0] y;
        logic               run_last;
        logic               frame_last;
    } point_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [15:0] sample
    logic        s_tlast = 1'b0; // last_sample
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [11:0] point_x, [24:12] point_y
    logic        m_tuser;        // run_last
    logic        m_tlast;        // frame_last

    waveform_minmax_decimator_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    sample_req_t pending_samples[$];
    point_t      expected_points[$];
    int          errors = 0;
    int          idle_pct = 19;
    int          stall_pct = 19;
    int          cycle_count = 0;

    // register copies
    logic [23:0] len_cfg = wmmd_pkg::SPS_RESET;
    logic [31:0] scale_cfg = wmmd_pkg::SCALE_RESET;
    logic [11:0] height_cfg = wmmd_pkg::HEIGHT_RESET;

    // envelope state
    logic [23:0]        next_index = '0;
    logic [23:0]        seg_fill = '0;
    logic signed [15:0] seg_hi = '0;
    logic signed [15:0] seg_lo = '0;
    logic [23:0]        hi_index = '0;
    logic [23:0]        lo_index = '0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (errors < 100)
            $display("MISMATCH @%0d: %s", cycle_count, msg);
        errors++;
    endtask

    function automatic point_t plot_point(input logic [23:0] idx, input logic signed [15:0] s,
                                          input logic run_last, input logic frame_last);
        point_t      p;
        logic [63:0] xw;
        int          si;
        int          hi;
        int          q;
        xw = (64'(idx) * 64'(scale_cfg)) >> 20;
        p.x = (xw > 64'd4095) ? 12'hFFF : xw[11:0];
        si = s;
        hi = height_cfg;
        q = -((si * hi) / 65536);
        p.y = q[12:0];
        p.run_last = run_last;
        p.frame_last = frame_last;
        return p;
    endfunction

    task automatic envelope_step(input logic signed [15:0] s, input logic last);
        logic [23:0] len;
        logic [23:0] idx;
        len = (len_cfg == 24'd0) ? 24'd1 : len_cfg;
        idx = next_index;
        if (seg_fill == 24'd0) begin
            seg_hi = s;
            seg_lo = s;
            hi_index = idx;
            lo_index = idx;
        end else begin
            if (s > seg_hi) begin
                seg_hi = s;
                hi_index = idx;
            end
            if (s < seg_lo) begin
                seg_lo = s;
                lo_index = idx;
            end
        end
        seg_fill = seg_fill + 24'd1;
        next_index = next_index + 24'd1;
        if (seg_fill >= len || seg_fill == 24'd0 || last) begin
            if (hi_index > lo_index) begin
                expected_points.push_back(plot_point(lo_index, seg_lo, 1'b0, 1'b0));
                expected_points.push_back(plot_point(hi_index, seg_hi, 1'b1, last));
            end else if (hi_index < lo_index) begin
                expected_points.push_back(plot_point(hi_index, seg_hi, 1'b0, 1'b0));
                expected_points.push_back(plot_point(lo_index, seg_lo, 1'b1, last));
            end else begin
                expected_points.push_back(plot_point(lo_index, seg_lo, 1'b1, last));
            end
            seg_fill = '0;
        end
        if (last) begin
            next_index = '0;
            seg_fill = '0;
        end
    endtask

    // sample driver
    always @(posedge aclk) begin : sample_driver
        sample_req_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                envelope_step(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (pending_samples.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    req = pending_samples.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= req.sample;
                    s_tlast <= req.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // point monitor
    always @(posedge aclk) begin : point_monitor
        point_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_points.size() == 0) begin
                    report_mismatch($sformatf("unexpected point %h", m_tdata));
                end else begin
                    want = expected_points.pop_front();
                    if (m_tdata[11:0] !== want.x)
                        report_mismatch($sformatf("point_x %0d, want %0d",
                                                  m_tdata[11:0], want.x));
                    if (m_tdata[24:12] !== want.y)
                        report_mismatch($sformatf("point_y %0d, want %0d",
                                                  $signed(m_tdata[24:12]), want.y));
                    if (m_tuser !== want.run_last)
                        report_mismatch($sformatf("run_last %b, want %b",
                                                  m_tuser, want.run_last));
                    if (m_tlast !== want.frame_last)
                        report_mismatch($sformatf("frame_last %b, want %b",
                                                  m_tlast, want.frame_last));
                end
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic reg_write(input wmmd_pkg::reg_index_t idx, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            wmmd_pkg::REG_SAMPLES_PER_SEGMENT: len_cfg = value[23:0];
            wmmd_pkg::REG_X_SCALE_Q20:         scale_cfg = value;
            wmmd_pkg::REG_PLOT_HEIGHT:         height_cfg = value[11:0];
            default: ;
        endcase
    endtask

    task automatic queue_sample(input logic signed [15:0] s, input logic last);
        sample_req_t req;
        req.sample = s;
        req.last = last;
        pending_samples.push_back(req);
    endtask

    // waits until every request is taken and every point has come back;
    // checked at the falling edge, once the driver's updates have settled
    task automatic drain();
        while (pending_samples.size() > 0 || s_tvalid || expected_points.size() > 0)
            @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int ph;
        int k;
        logic [31:0] v;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset defaults: one point per sample
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(-16'sh8000, 1'b0);
        queue_sample(16'sh0000, 1'b0);
        queue_sample(-16'sh0001, 1'b0);
        queue_sample(16'sh0001, 1'b1);
        drain();

        // zero length behaves as one; x saturates at the full scale
        reg_write(wmmd_pkg::REG_SAMPLES_PER_SEGMENT, 32'd0);
        reg_write(wmmd_pkg::REG_X_SCALE_Q20, 32'hFFF0_0000);
        reg_write(wmmd_pkg::REG_PLOT_HEIGHT, 32'd4095);
        queue_sample(-16'sh8000, 1'b0);
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(16'sh1234, 1'b1);
        drain();

        // ties, ordering, flush mid-segment; writes past the map are ignored
        reg_write(wmmd_pkg::REG_SAMPLES_PER_SEGMENT, 32'd4);
        reg_write(wmmd_pkg::REG_X_SCALE_Q20, 32'h0030_0000);
        reg_write(wmmd_pkg::REG_PLOT_HEIGHT, 32'd0);
        reg_write(wmmd_pkg::REG_UNUSED, 32'hFFFF_FFFF);
        reg_write(wmmd_pkg::REG_PLOT_HEIGHT, 32'd1000);
        queue_sample(16'sd5, 1'b0);
        queue_sample(16'sd5, 1'b0);
        queue_sample(16'sd5, 1'b0);
        queue_sample(16'sd5, 1'b0);
        queue_sample(16'sd100, 1'b0);
        queue_sample(-16'sd100, 1'b0);
        queue_sample(16'sd100, 1'b0);
        queue_sample(-16'sd100, 1'b0);
        queue_sample(-16'sd7, 1'b0);
        queue_sample(16'sd9, 1'b1);
        drain();

        // length lowered while a segment is open
        reg_write(wmmd_pkg::REG_SAMPLES_PER_SEGMENT, 32'd8);
        for (k = 0; k < 5; k++)
            queue_sample(random_sample(), 1'b0);
        drain();
        reg_write(wmmd_pkg::REG_SAMPLES_PER_SEGMENT, 32'd3);
        queue_sample(random_sample(), 1'b0);
        queue_sample(random_sample(), 1'b0);
        queue_sample(random_sample(), 1'b0);
        queue_sample(random_sample(), 1'b1);
        drain();

        // longest segment, closed only by the end of data
        reg_write(wmmd_pkg::REG_SAMPLES_PER_SEGMENT, 32'h00FF_FFFF);
        reg_write(wmmd_pkg::REG_X_SCALE_Q20, 32'd0);
        for (k = 0; k < 12; k++)
            queue_sample(random_sample(), k == 11);
        drain();

        for (ph = 0; ph < 12; ph++) begin
            case ($urandom_range(0, 9))
                0: v = 32'd0;
                1: v = 32'h00FF_FFFF;
                2: v = $urandom;
                default: v = $urandom_range(1, 12);
            endcase
            reg_write(wmmd_pkg::REG_SAMPLES_PER_SEGMENT, v);
            case ($urandom_range(0, 5))
                0: v = 32'd0;
                1: v = 32'hFFF0_0000;
                2: v = $urandom;
                default: v = $urandom_range(0, 32'h0040_0000);
            endcase
            reg_write(wmmd_pkg::REG_X_SCALE_Q20, v);
            case ($urandom_range(0, 4))
                0: v = 32'd0;
                1: v = 32'd4095;
                default: v = $urandom;
            endcase
            reg_write(wmmd_pkg::REG_PLOT_HEIGHT, v);
            reg_write(wmmd_pkg::REG_UNUSED, $urandom);
            if (ph == 5) begin
                idle_pct = 0;
                stall_pct = 0;
            end else begin
                idle_pct = 19;
                stall_pct = 19;
            end
            for (k = 0; k < 145; k++)
                queue_sample(random_sample(), $urandom_range(0, 39) == 0);
            drain();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
